### sv/floyd_steinberg_palette_dither_assert.svh
// Assertion macros shared by the dither modules.
// Each check is sampled on the rising clock and is off while reset is held.
`ifndef FLOYD_STEINBERG_PALETTE_DITHER_ASSERT_SVH
`define FLOYD_STEINBERG_PALETTE_DITHER_ASSERT_SVH
`ifndef SYNTHESIS
`define FSPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define FSPD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define FSPD_ASSERT(lbl, prop, msg)
`define FSPD_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

### sv/fspd_pkg.sv
package fspd_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_PALETTE_SIZE = 3'd2;
  localparam logic [2:0] REG_ALPHA_LIMIT  = 3'd3;
  localparam logic [2:0] REG_HAS_ALPHA    = 3'd4;

  // Request type codes.
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_PIXEL = 1'b1;

  // Accumulation steps, in the order the contributions are applied.
  localparam logic [1:0] STEP_UP_LEFT  = 2'd0;
  localparam logic [1:0] STEP_UP       = 2'd1;
  localparam logic [1:0] STEP_UP_RIGHT = 2'd2;
  localparam logic [1:0] STEP_LEFT     = 2'd3;

  // Squared distance width and its starting value.
  localparam int unsigned DIST_W = 18;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_SEARCH,
    ST_DRAIN,
    ST_ERR,
    ST_WRITE
  } state_e;

  typedef struct packed {
    logic [10:0] image_width;
    logic [10:0] image_height;
    logic [8:0]  palette_size;
    logic [7:0]  alpha_limit;
    logic        has_alpha;
  } cfg_t;

  typedef struct packed {
    logic       start;
    logic       load;
    logic       acc_en;
    logic [1:0] acc_step;
    logic       search_issue;
    logic       err_calc;
    logic       commit;
  } cmd_t;

  typedef struct packed {
    logic search_last;
    logic pipe_busy;
    logic out_blocked;
  } status_t;

endpackage

### sv/floyd_steinberg_palette_dither.sv
// Channel   Direction  Handshake               Payload
// in        input      in_valid_i / in_stall_o  req_type, entry_index, red, green, blue, alpha
// out       output     out_valid_o / out_stall_i out_red, out_green, out_blue, out_alpha,
//                                                chosen_index
// cfg       input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// The nearest-colour search of a pixel reads N palette entries (one for a transparent
// pixel), one entry per cycle from the single palette read port.
// Reset clears position, carried errors and the output valid flag; the stores need none.
// A result waits in the output register while the next item is accepted; a stalled
// result holds the block at its write-back step.
`include "floyd_steinberg_palette_dither_assert.svh"

module floyd_steinberg_palette_dither #(
  parameter int unsigned MAX_WIDTH     = 1024,
  parameter int unsigned PALETTE_DEPTH = 256,
  parameter int unsigned FRAC_BITS     = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [7:0]  entry_index_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  input  logic [7:0]  alpha_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_red_o,
  output logic [7:0]  out_green_o,
  output logic [7:0]  out_blue_o,
  output logic [7:0]  out_alpha_o,
  output logic [7:0]  chosen_index_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [10:0] cfg_data_i
);

  fspd_pkg::cfg_t    cfg_q;
  fspd_pkg::cmd_t    cmd;
  fspd_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  // Configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width  <= 11'd320;
      cfg_q.image_height <= 11'd240;
      cfg_q.palette_size <= 9'd256;
      cfg_q.alpha_limit  <= 8'd128;
      cfg_q.has_alpha    <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        fspd_pkg::REG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_data_i;
        fspd_pkg::REG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_data_i;
        fspd_pkg::REG_PALETTE_SIZE: cfg_q.palette_size <= cfg_data_i[8:0];
        fspd_pkg::REG_ALPHA_LIMIT:  cfg_q.alpha_limit  <= cfg_data_i[7:0];
        fspd_pkg::REG_HAS_ALPHA:    cfg_q.has_alpha    <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  fspd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  fspd_datapath #(
    .MAX_WIDTH     (MAX_WIDTH),
    .PALETTE_DEPTH (PALETTE_DEPTH),
    .FRAC_BITS     (FRAC_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .cmd_i          (cmd),
    .status_o       (status),
    .entry_index_i  (entry_index_i),
    .red_i          (red_i),
    .green_i        (green_i),
    .blue_i         (blue_i),
    .alpha_i        (alpha_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_red_o      (out_red_o),
    .out_green_o    (out_green_o),
    .out_blue_o     (out_blue_o),
    .out_alpha_o    (out_alpha_o),
    .chosen_index_o (chosen_index_o)
  );

  // Only one of the commands that touch the stores is given in a cycle.
  `FSPD_ASSERT_NEVER(a_one_store_cmd, cmd.load && cmd.commit, "load during commit")

endmodule

### sv/fspd_ram.sv
module fspd_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/fspd_ctrl.sv
`include "floyd_steinberg_palette_dither_assert.svh"

module fspd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              req_type_i,
  output logic              in_stall_o,
  input  fspd_pkg::status_t status_i,
  output fspd_pkg::cmd_t    cmd_o
);

  fspd_pkg::state_e state_q, state_d;
  logic [1:0]       step_q, step_d;

  // State and step registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fspd_pkg::ST_IDLE;
      step_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Next state and commands to the datapath.
  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      fspd_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        step_d     = 2'd0;
        if (in_valid_i) begin
          if (req_type_i == fspd_pkg::REQ_PIXEL) begin
            cmd_o.start = 1'b1;
            state_d     = fspd_pkg::ST_ACC;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      fspd_pkg::ST_ACC: begin
        cmd_o.acc_en   = 1'b1;
        cmd_o.acc_step = step_q;
        step_d         = step_q + 2'd1;
        if (step_q == fspd_pkg::STEP_LEFT) begin
          state_d = fspd_pkg::ST_SEARCH;
        end
      end
      fspd_pkg::ST_SEARCH: begin
        cmd_o.search_issue = 1'b1;
        if (status_i.search_last) begin
          state_d = fspd_pkg::ST_DRAIN;
        end
      end
      fspd_pkg::ST_DRAIN: begin
        if (!status_i.pipe_busy) begin
          state_d = fspd_pkg::ST_ERR;
        end
      end
      fspd_pkg::ST_ERR: begin
        cmd_o.err_calc = 1'b1;
        state_d        = fspd_pkg::ST_WRITE;
      end
      fspd_pkg::ST_WRITE: begin
        if (!status_i.out_blocked) begin
          cmd_o.commit = 1'b1;
          state_d      = fspd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fspd_pkg::ST_IDLE;
      end
    endcase
  end

  // The last palette address is followed by the pipeline drain.
  `FSPD_ASSERT(a_search_to_drain, (state_q == fspd_pkg::ST_SEARCH && status_i.search_last) |=> (state_q == fspd_pkg::ST_DRAIN), "search did not end in drain")

endmodule

### sv/fspd_datapath.sv
`include "floyd_steinberg_palette_dither_assert.svh"

module fspd_datapath #(
  parameter int unsigned MAX_WIDTH     = 1024,
  parameter int unsigned PALETTE_DEPTH = 256,
  parameter int unsigned FRAC_BITS     = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fspd_pkg::cfg_t    cfg_i,
  input  fspd_pkg::cmd_t    cmd_i,
  output fspd_pkg::status_t status_o,
  input  logic [7:0]        entry_index_i,
  input  logic [7:0]        red_i,
  input  logic [7:0]        green_i,
  input  logic [7:0]        blue_i,
  input  logic [7:0]        alpha_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        out_red_o,
  output logic [7:0]        out_green_o,
  output logic [7:0]        out_blue_o,
  output logic [7:0]        out_alpha_o,
  output logic [7:0]        chosen_index_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned AW = $clog2(PALETTE_DEPTH);
  localparam int unsigned VW = 8 + FRAC_BITS;
  localparam int unsigned EW = VW + 1;
  localparam int unsigned PW = EW + 4;
  localparam int unsigned DIST_W_L = fspd_pkg::DIST_W;
  localparam logic [VW-1:0] TOP_VALUE = VW'(255) << FRAC_BITS;

  // Effective sizes from the registers.
  logic [13:0] width_eff;
  logic [11:0] height_eff;
  logic [8:0]  pal_eff;
  logic [8:0]  search_lim;
  logic [13:0] x_next;
  logic [11:0] y_next;
  logic        last_col;
  logic        last_row;

  // Position and carried errors.
  logic [CW-1:0]           x_q;
  logic [10:0]             y_q;
  logic [2:0][EW-1:0]      left_q;
  logic [2:0][EW-1:0]      upleft_q;

  // Pixel working registers.
  logic                    transp_q;
  logic [2:0][VW-1:0]      acc_q;
  logic [2:0][VW-1:0]      acc_d;

  // Search pipeline.
  logic [AW-1:0]           issue_q;
  logic                    v1_q, v2_q;
  logic [AW-1:0]           tag1_q, tag2_q;
  logic [DIST_W_L-1:0]     d_q;
  logic [23:0]             rgb2_q;
  logic [DIST_W_L-1:0]     sq_dist;
  logic [DIST_W_L-1:0]     best_q;
  logic [AW-1:0]           best_idx_q;
  logic [23:0]             best_rgb_q;
  logic [23:0]             pal_rdata;

  // Error shares.
  logic [2:0][EW-1:0]      q1_q, q3_q, q5_q, q7_q;
  logic [2:0][EW-1:0]      q1_d, q3_d, q5_d, q7_d;

  // Row error stores.
  logic [6*EW-1:0]         rowa_rdata;
  logic [3*EW-1:0]         rowb_rdata;
  logic [6*EW-1:0]         rowa_wdata;
  logic [3*EW-1:0]         rowb_wdata;

  // Output register.
  logic                    out_valid_q;
  logic [2:0][7:0]         out_rgb_q;
  logic [7:0]              out_alpha_q;
  logic [7:0]              out_idx_q;

  logic [7:0] alpha_eff;
  logic       pal_we;

  // Clamp the register values to their working ranges.
  always_comb begin
    width_eff = (cfg_i.image_width == 11'd0) ? 14'd1 : 14'(cfg_i.image_width);
    if (width_eff > 14'(MAX_WIDTH)) begin
      width_eff = 14'(MAX_WIDTH);
    end
    height_eff = (cfg_i.image_height == 11'd0) ? 12'd1 : 12'(cfg_i.image_height);
    pal_eff    = (cfg_i.palette_size == 9'd0) ? 9'd1 : cfg_i.palette_size;
    if (10'(pal_eff) > 10'(PALETTE_DEPTH)) begin
      pal_eff = 9'(PALETTE_DEPTH);
    end
    search_lim = transp_q ? 9'd1 : pal_eff;
    x_next     = 14'(x_q) + 14'd1;
    y_next     = 12'(y_q) + 12'd1;
    last_col   = x_next >= width_eff;
    last_row   = y_next >= height_eff;
  end

  assign alpha_eff = cfg_i.has_alpha ? alpha_i : 8'd255;

  // Palette store: loads write, the search reads.
  assign pal_we = cmd_i.load && ({1'b0, entry_index_i} < 9'(PALETTE_DEPTH));

  fspd_ram #(
    .WIDTH (24),
    .DEPTH (PALETTE_DEPTH)
  ) u_pal_ram (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (entry_index_i[AW-1:0]),
    .wdata_i ({red_i, green_i, blue_i}),
    .re_i    (cmd_i.search_issue),
    .raddr_i (issue_q),
    .rdata_o (pal_rdata)
  );

  // Row store A holds up-left and up shares at each column.
  assign rowa_wdata = {q5_q, upleft_q};

  fspd_ram #(
    .WIDTH (6 * EW),
    .DEPTH (MAX_WIDTH)
  ) u_rowa_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit),
    .waddr_i (x_q),
    .wdata_i (rowa_wdata),
    .re_i    (cmd_i.start),
    .raddr_i (x_q),
    .rdata_o (rowa_rdata)
  );

  // Row store B holds the up-right share, written one column back.
  assign rowb_wdata = q3_q;

  fspd_ram #(
    .WIDTH (3 * EW),
    .DEPTH (MAX_WIDTH)
  ) u_rowb_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit && (x_q != '0)),
    .waddr_i (x_q - CW'(1)),
    .wdata_i (rowb_wdata),
    .re_i    (cmd_i.start),
    .raddr_i (x_q),
    .rdata_o (rowb_rdata)
  );

  // One clamped addition per channel for the current step.
  always_comb begin
    logic [EW-1:0]   contrib;
    logic            use_it;
    logic [VW+1:0]   sum;
    acc_d = acc_q;
    for (int c = 0; c < 3; c++) begin
      contrib = '0;
      use_it  = 1'b0;
      unique case (cmd_i.acc_step)
        fspd_pkg::STEP_UP_LEFT: begin
          contrib = rowa_rdata[c*EW +: EW];
          use_it  = (y_q != '0) && (x_q != '0);
        end
        fspd_pkg::STEP_UP: begin
          contrib = rowa_rdata[(3+c)*EW +: EW];
          use_it  = (y_q != '0);
        end
        fspd_pkg::STEP_UP_RIGHT: begin
          contrib = rowb_rdata[c*EW +: EW];
          use_it  = (y_q != '0) && !last_col;
        end
        fspd_pkg::STEP_LEFT: begin
          contrib = left_q[c];
          use_it  = (x_q != '0);
        end
        default: begin
          contrib = '0;
        end
      endcase
      sum = $signed({2'b00, acc_q[c]}) + $signed({contrib[EW-1], contrib});
      if (use_it) begin
        if (sum[VW+1]) begin
          acc_d[c] = '0;
        end else if (sum > {2'b00, TOP_VALUE}) begin
          acc_d[c] = TOP_VALUE;
        end else begin
          acc_d[c] = sum[VW-1:0];
        end
      end
    end
  end

  // Squared RGB distance of the entry just read.
  always_comb begin
    logic signed [8:0]  diff;
    logic        [17:0] sq;
    sq_dist = '0;
    for (int c = 0; c < 3; c++) begin
      diff = $signed({1'b0, acc_q[c][VW-1:FRAC_BITS]})
           - $signed({1'b0, pal_rdata[(2-c)*8 +: 8]});
      sq   = 18'(diff * diff);
      sq_dist = sq_dist + DIST_W_L'(sq);
    end
  end

  // Error and its four shares, truncated toward zero.
  function automatic logic [EW-1:0] share(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] r;
    r = p[PW-1] ? ((p + PW'(15)) >>> 4) : (p >>> 4);
    return r[EW-1:0];
  endfunction

  always_comb begin
    logic signed [EW:0]   err;
    logic signed [PW-1:0] e;
    for (int c = 0; c < 3; c++) begin
      err = $signed({2'b00, acc_q[c]})
          - $signed({2'b00, best_rgb_q[(2-c)*8 +: 8], FRAC_BITS'(0)});
      e   = PW'(err);
      q1_d[c] = share(e);
      q3_d[c] = share(e * PW'(3));
      q5_d[c] = share(e * PW'(5));
      q7_d[c] = share(e * PW'(7));
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q         <= '0;
      y_q         <= '0;
      left_q      <= '0;
      upleft_q    <= '0;
      issue_q     <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.search_issue;
      v2_q <= v1_q;
      if (cmd_i.start) begin
        issue_q <= '0;
      end else if (cmd_i.search_issue) begin
        issue_q <= issue_q + AW'(1);
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.commit) begin
        left_q      <= q7_q;
        upleft_q    <= q1_q;
        if (last_col) begin
          x_q <= '0;
          y_q <= last_row ? 11'd0 : y_next[10:0];
        end else begin
          x_q <= x_next[CW-1:0];
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      transp_q <= alpha_eff < cfg_i.alpha_limit;
      acc_q[0] <= VW'(red_i) << FRAC_BITS;
      acc_q[1] <= VW'(green_i) << FRAC_BITS;
      acc_q[2] <= VW'(blue_i) << FRAC_BITS;
      best_q   <= fspd_pkg::DIST_MAX;
    end else if (cmd_i.acc_en) begin
      acc_q <= acc_d;
    end
    if (cmd_i.search_issue) begin
      tag1_q <= issue_q;
    end
    if (v1_q) begin
      d_q    <= sq_dist;
      tag2_q <= tag1_q;
      rgb2_q <= pal_rdata;
    end
    if (v2_q && (d_q < best_q)) begin
      best_q     <= d_q;
      best_idx_q <= tag2_q;
      best_rgb_q <= rgb2_q;
    end
    if (cmd_i.err_calc) begin
      q1_q <= q1_d;
      q3_q <= q3_d;
      q5_q <= q5_d;
      q7_q <= q7_d;
    end
    if (cmd_i.commit) begin
      out_rgb_q   <= {best_rgb_q[7:0], best_rgb_q[15:8], best_rgb_q[23:16]};
      out_alpha_q <= transp_q ? 8'd0 : 8'd255;
      out_idx_q   <= 8'(best_idx_q);
    end
  end

  // Status to the controller.
  assign status_o.search_last = (9'(issue_q) == (search_lim - 9'd1));
  assign status_o.pipe_busy   = v1_q || v2_q;
  assign status_o.out_blocked = out_valid_q && out_stall_i;

  assign out_valid_o    = out_valid_q;
  assign out_red_o      = out_rgb_q[0];
  assign out_green_o    = out_rgb_q[1];
  assign out_blue_o     = out_rgb_q[2];
  assign out_alpha_o    = out_alpha_q;
  assign chosen_index_o = out_idx_q;

  // A waiting result is never overwritten.
  `FSPD_ASSERT_NEVER(a_no_overwrite, cmd_i.commit && out_valid_q && out_stall_i, "result overwritten")
  // The best distance only falls while the search runs.
  `FSPD_ASSERT(a_best_falls, (v2_q && !cmd_i.start) |=> (best_q <= $past(best_q)), "best distance grew")
  // A result appears only after a commit.
  `FSPD_ASSERT(a_valid_from_commit, $rose(out_valid_q) |-> $past(cmd_i.commit), "result without commit")

endmodule

### bench/fspd_checker.sv
`timescale 1ns / 100ps

// Watches the three channels of the dither block, predicts every pixel result
// and compares each output transfer with the oldest prediction.
module fspd_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        req_type_i,
  input  logic [7:0]  entry_index_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  input  logic [7:0]  alpha_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [7:0]  out_red_i,
  input  logic [7:0]  out_green_i,
  input  logic [7:0]  out_blue_i,
  input  logic [7:0]  out_alpha_i,
  input  logic [7:0]  chosen_index_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [10:0] cfg_data_i,
  output int          errors_o,
  output int          pending_o
);

  localparam int FB     = 8;
  localparam int WMAX   = 1024;
  localparam int PDEPTH = 256;
  localparam int TOPV   = 255 << FB;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] index;
  } pixel_out_t;

  // Predicted state of the block.
  logic [7:0]      palette [PDEPTH][3];
  int              line_err [WMAX][3][3];
  int              left_err [3];
  int              up_left_err [3];
  int              col_pos;
  int              row_pos;
  fspd_pkg::cfg_t  cfg;
  pixel_out_t      dither_q [$];

  function automatic int clamp_add(int v, int e);
    int t;
    t = v + e;
    if (t < 0) return 0;
    if (t > TOPV) return TOPV;
    return t;
  endfunction

  // Quantize one pixel, spread its error and queue the expected output.
  function automatic void dither_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                       logic [7:0] a);
    int w, h, n, x, y, best, sq_dist, diff, idx, av, c, k;
    int acc [3];
    int err [3];
    logic [7:0] chan [3];
    bit clear;
    pixel_out_t res;
    chan[0] = r;
    chan[1] = g;
    chan[2] = b;
    w = (cfg.image_width == 0) ? 1 : int'(cfg.image_width);
    if (w > WMAX) w = WMAX;
    h = (cfg.image_height == 0) ? 1 : int'(cfg.image_height);
    n = (cfg.palette_size == 0) ? 1 : int'(cfg.palette_size);
    if (n > PDEPTH) n = PDEPTH;
    x = col_pos;
    y = row_pos;
    for (c = 0; c < 3; c++) begin
      acc[c] = int'(chan[c]) << FB;
      if (y > 0) begin
        if (x > 0) acc[c] = clamp_add(acc[c], line_err[x][0][c]);
        acc[c] = clamp_add(acc[c], line_err[x][1][c]);
        if (x + 1 < w) acc[c] = clamp_add(acc[c], line_err[x][2][c]);
      end
      if (x > 0) acc[c] = clamp_add(acc[c], left_err[c]);
    end
    av = cfg.has_alpha ? int'(a) : 255;
    clear = av < int'(cfg.alpha_limit);
    idx = 0;
    if (!clear) begin
      best = -1;
      for (k = 0; k < n; k++) begin
        sq_dist = 0;
        for (c = 0; c < 3; c++) begin
          diff = (acc[c] >> FB) - int'(palette[k][c]);
          sq_dist += diff * diff;
        end
        if (best < 0 || sq_dist < best) begin
          best = sq_dist;
          idx = k;
        end
      end
    end
    // Error shares truncate toward zero, as integer division does.
    for (c = 0; c < 3; c++) begin
      err[c] = acc[c] - (int'(palette[idx][c]) << FB);
      if (x > 0) line_err[x-1][2][c] = (err[c] * 3) / 16;
      line_err[x][0][c] = up_left_err[c];
      line_err[x][1][c] = (err[c] * 5) / 16;
      up_left_err[c] = err[c] / 16;
      left_err[c] = (err[c] * 7) / 16;
    end
    res.red   = palette[idx][0];
    res.green = palette[idx][1];
    res.blue  = palette[idx][2];
    res.alpha = clear ? 8'd0 : 8'd255;
    res.index = idx[7:0];
    dither_q.insert(dither_q.size(), res);
    if (x + 1 >= w) begin
      col_pos = 0;
      row_pos = (y + 1 >= h) ? 0 : y + 1;
    end else begin
      col_pos = x + 1;
    end
  endfunction

  function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (exp_v !== act_v) begin
      errors_o++;
      if (errors_o <= 10) begin
        $display("mismatch %s: expected %0d, got %0d at %0t", name, exp_v, act_v, $time);
      end
    end
  endfunction

  always @(posedge clk_i) begin
    pixel_out_t exp_r;
    if (!rst_ni) begin
      errors_o = 0;
      foreach (palette[i, c]) palette[i][c] = '0;
      foreach (line_err[i, j, c]) line_err[i][j][c] = 0;
      for (int c = 0; c < 3; c++) begin
        left_err[c] = 0;
        up_left_err[c] = 0;
      end
      col_pos = 0;
      row_pos = 0;
      cfg.image_width  = 11'd320;
      cfg.image_height = 11'd240;
      cfg.palette_size = 9'd256;
      cfg.alpha_limit  = 8'd128;
      cfg.has_alpha    = 1'b1;
      dither_q.delete();
    end else begin
      // Register write transfer.
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          fspd_pkg::REG_IMAGE_WIDTH:  cfg.image_width  = cfg_data_i;
          fspd_pkg::REG_IMAGE_HEIGHT: cfg.image_height = cfg_data_i;
          fspd_pkg::REG_PALETTE_SIZE: cfg.palette_size = cfg_data_i[8:0];
          fspd_pkg::REG_ALPHA_LIMIT:  cfg.alpha_limit  = cfg_data_i[7:0];
          fspd_pkg::REG_HAS_ALPHA:    cfg.has_alpha    = cfg_data_i[0];
          default: ;
        endcase
      end
      // Output transfer against the oldest prediction.
      if (out_valid_i && !out_stall_i) begin
        if (dither_q.size() == 0) begin
          errors_o++;
          if (errors_o <= 10) $display("unexpected output transfer at %0t", $time);
        end else begin
          exp_r = dither_q.pop_front();
          check_field("out_red", exp_r.red, out_red_i);
          check_field("out_green", exp_r.green, out_green_i);
          check_field("out_blue", exp_r.blue, out_blue_i);
          check_field("out_alpha", exp_r.alpha, out_alpha_i);
          check_field("chosen_index", exp_r.index, chosen_index_i);
        end
      end
      // Input transfer: palette load or pixel.
      if (in_valid_i && !in_stall_i) begin
        if (req_type_i == fspd_pkg::REQ_LOAD) begin
          palette[entry_index_i][0] = red_i;
          palette[entry_index_i][1] = green_i;
          palette[entry_index_i][2] = blue_i;
        end else begin
          dither_pixel(red_i, green_i, blue_i, alpha_i);
        end
      end
    end
    pending_o <= dither_q.size();
  end

endmodule

### bench/floyd_steinberg_palette_dither_tb.sv
`timescale 1ns / 100ps

module floyd_steinberg_palette_dither_tb;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        req_type;
  logic [7:0]  entry_index;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [7:0]  out_alpha;
  logic [7:0]  chosen_index;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [10:0] cfg_data;
  int          errors;
  int          pending;
  int          idle_pct;
  int          stall_pct;

  always #5 clk = ~clk;

  floyd_steinberg_palette_dither dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .req_type_i(req_type), .entry_index_i(entry_index),
    .red_i(red), .green_i(green), .blue_i(blue), .alpha_i(alpha),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .out_red_o(out_red), .out_green_o(out_green), .out_blue_o(out_blue),
    .out_alpha_o(out_alpha), .chosen_index_o(chosen_index),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  fspd_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .req_type_i(req_type), .entry_index_i(entry_index),
    .red_i(red), .green_i(green), .blue_i(blue), .alpha_i(alpha),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .out_red_i(out_red), .out_green_i(out_green), .out_blue_i(out_blue),
    .out_alpha_i(out_alpha), .chosen_index_i(chosen_index),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .errors_o(errors), .pending_o(pending)
  );

  // The receiver stalls at random with the current phase's rate.
  always @(posedge clk) begin
    out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
  end

  // One input transfer, then a random gap with the valid low.
  task automatic send_item(logic kind, logic [7:0] ei, logic [7:0] r, logic [7:0] g,
                           logic [7:0] b, logic [7:0] a);
    in_valid <= 1'b1;
    req_type <= kind;
    entry_index <= ei;
    red <= r;
    green <= g;
    blue <= b;
    alpha <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [2:0] idx, logic [10:0] val);
    in_valid <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every predicted pixel has left, then let a search finish.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_frame(int w, int h, int n, int lim, int ha);
    write_reg(fspd_pkg::REG_IMAGE_WIDTH, w[10:0]);
    write_reg(fspd_pkg::REG_IMAGE_HEIGHT, h[10:0]);
    write_reg(fspd_pkg::REG_PALETTE_SIZE, n[10:0]);
    write_reg(fspd_pkg::REG_ALPHA_LIMIT, lim[10:0]);
    write_reg(fspd_pkg::REG_HAS_ALPHA, ha[10:0]);
  endtask

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  // Phase settings: width, height, palette size, alpha limit, alpha enable.
  int phase_cfg [8][5] = '{
    '{5, 4, 256, 128, 1}, '{0, 3, 0, 0, 1}, '{9, 1, 16, 255, 1},
    '{1, 40, 8, 64, 0}, '{7, 6, 300, 200, 0}, '{16, 2, 256, 50, 1},
    '{33, 1, 128, 128, 1}, '{3, 2, 2, 255, 0}
  };
  int idle_modes [4][2] = '{'{0, 0}, '{76, 0}, '{0, 76}, '{36, 36}};

  initial begin
    int w, h, frame_px, sent;
    rst_n = 1'b0;
    in_valid = 1'b0;
    req_type = fspd_pkg::REQ_LOAD;
    entry_index = '0;
    red = '0;
    green = '0;
    blue = '0;
    alpha = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    idle_pct = 0;
    stall_pct = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill the whole palette; entries one and two are equal so ties occur.
    for (int i = 0; i < 256; i++) begin
      case (i)
        0: send_item(fspd_pkg::REQ_LOAD, 8'(i), 8'd0, 8'd0, 8'd0, 8'($urandom));
        1, 2: send_item(fspd_pkg::REQ_LOAD, 8'(i), 8'd128, 8'd128, 8'd128, 8'($urandom));
        255: send_item(fspd_pkg::REQ_LOAD, 8'(i), 8'd255, 8'd255, 8'd255, 8'($urandom));
        default: send_item(fspd_pkg::REQ_LOAD, 8'(i), rand_chan(), rand_chan(), rand_chan(),
                           8'($urandom));
      endcase
    end

    // Directed frame: extremes, alpha at the limit, ties and a reload.
    write_reg(3'd7, 11'h7ff);
    set_frame(4, 3, 256, 128, 1);
    send_item(fspd_pkg::REQ_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255);
    send_item(fspd_pkg::REQ_PIXEL, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255);
    send_item(fspd_pkg::REQ_PIXEL, 8'd0, 8'd128, 8'd128, 8'd128, 8'd128);
    send_item(fspd_pkg::REQ_PIXEL, 8'd0, 8'd200, 8'd10, 8'd90, 8'd127);
    send_item(fspd_pkg::REQ_PIXEL, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0);
    send_item(fspd_pkg::REQ_LOAD, 8'd3, 8'd255, 8'd0, 8'd0, 8'd0);
    send_item(fspd_pkg::REQ_PIXEL, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255);
    send_item(fspd_pkg::REQ_PIXEL, 8'd0, 8'd0, 8'd255, 8'd0, 8'd255);
    send_item(fspd_pkg::REQ_PIXEL, 8'd0, 8'd128, 8'd128, 8'd128, 8'd255);
    send_item(fspd_pkg::REQ_PIXEL, 8'd0, 8'd1, 8'd254, 8'd1, 8'd254);
    for (int i = 0; i < 15; i++) begin
      send_item(fspd_pkg::REQ_PIXEL, 8'($urandom), rand_chan(), rand_chan(), rand_chan(),
                8'($urandom));
    end
    drain();

    // Random phases of whole frames with palette reloads mixed in.
    for (int p = 0; p < 8; p++) begin
      idle_pct = idle_modes[p % 4][0];
      stall_pct = idle_modes[p % 4][1];
      set_frame(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2], phase_cfg[p][3],
                phase_cfg[p][4]);
      w = (phase_cfg[p][0] == 0) ? 1 : (phase_cfg[p][0] > 1024 ? 1024 : phase_cfg[p][0]);
      h = (phase_cfg[p][1] == 0) ? 1 : phase_cfg[p][1];
      frame_px = w * h;
      sent = 0;
      while (sent < 30) begin
        for (int k = 0; k < frame_px; k++) begin
          if ($urandom_range(9) == 0) begin
            send_item(fspd_pkg::REQ_LOAD, 8'($urandom), rand_chan(), rand_chan(),
                      rand_chan(), 8'($urandom));
          end
          send_item(fspd_pkg::REQ_PIXEL, 8'($urandom), rand_chan(), rand_chan(), rand_chan(),
                    ($urandom_range(3) == 0) ? 8'(phase_cfg[p][3] - 1 + $urandom_range(2))
                                             : 8'($urandom));
        end
        sent += frame_px;
      end
      drain();
    end

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
